// ===== rtl/core/transition_stats_recorder_macros.svh =====
// Assertion macros used by the checker file.
`ifndef TRANSITION_STATS_RECORDER_MACROS_SVH
`define TRANSITION_STATS_RECORDER_MACROS_SVH
// Implication checked on every rising edge outside reset.
`define TSR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// Next-cycle implication checked on every rising edge outside reset.
`define TSR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

// ===== rtl/core/tsr_pkg.sv =====
package tsr_pkg;
  localparam int DefNumStates  = 64;
  localparam int DefNumActions = 8;
  localparam int DefCountBits  = 32;
  localparam int RewardBits    = 32;
  localparam int SumBits       = 63;
  localparam int StepBits      = 48;
  localparam int InDataBits    = 48;
  localparam int OutDataBits   = 208;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_LOAD, ST_DIV, ST_MUL, ST_ACC, ST_WRITE
  } state_t;

  typedef struct packed {
    logic        start;
    logic        busy;
  } div_ctrl_t;
endpackage

// ===== rtl/core/tsr_ram.sv =====
module tsr_ram #(
  parameter int Width = 32,
  parameter int Depth = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/tsr_div.sv =====
// Restoring divider: signed 33-bit dividend by unsigned divisor, quotient
// truncated toward zero. One quotient bit per cycle.
module tsr_div #(
  parameter int CountBits = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tsr_pkg::div_ctrl_t    ctrl,
  input  logic signed [32:0]    dividend,
  input  logic [CountBits-1:0]  divisor,
  output logic                  done,
  output logic signed [33:0]    quotient
);
  logic [32:0]          rem_r, rem_nxt;
  logic [32:0]          quo_r, quo_nxt;
  logic [32:0]          num_r, num_nxt;
  logic [CountBits-1:0] den_r, den_nxt;
  logic                 neg_r, neg_nxt;
  logic [5:0]           cnt_r, cnt_nxt;
  logic                 run_r, run_nxt;
  logic [33:0]          trial;
  logic [32:0]          shifted;

  always_comb begin
    shifted = {rem_r[31:0], num_r[32]};
    trial   = {1'b0, shifted} - {{(34-CountBits){1'b0}}, den_r};
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    num_nxt = num_r;
    den_nxt = den_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    if (ctrl.start) begin
      rem_nxt = '0;
      quo_nxt = '0;
      num_nxt = dividend[32] ? 33'(-dividend) : 33'(dividend);
      den_nxt = divisor;
      neg_nxt = dividend[32];
      cnt_nxt = 6'd33;
      run_nxt = 1'b1;
    end else if (run_r) begin
      num_nxt = {num_r[31:0], 1'b0};
      if (!trial[33]) begin
        rem_nxt = trial[32:0];
        quo_nxt = {quo_r[31:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[31:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = !run_r && !ctrl.start && ctrl.busy;
  assign quotient = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
endmodule

// ===== rtl/core/transition_stats_recorder.sv =====
// Channel | Transfer content (tdata, lowest bit first)
// in_*    | state[5:0] action[8:6] next_state[14:9] reward[46:15], pad to 48 bits
// out_*   | count[31:0] pair[63:32] mean[95:64] sq_sum[158:96] steps[206:159], pad 208
//
// From acceptance a transfer passes through the accepting idle state, a memory read
// state, a load state that starts the divider, the divider states (33 quotient bits,
// one a cycle, and a finishing step), then multiply, accumulate and write-back,
// before the next transfer can be accepted. The serial divider is the longest step.
// After reset a clearing pass of NUM_STATES*NUM_ACTIONS*NUM_STATES entries (32768 by
// default) zeroes the memories; in_tready stays low meanwhile. The output register
// parts the two sides: while a result waits with out_tready low the next transfer
// is still taken and processed, and it waits in write-back until the register is
// free. Inputs with an index out of range produce no result.
module transition_stats_recorder #(
  parameter int NUM_STATES  = tsr_pkg::DefNumStates,
  parameter int NUM_ACTIONS = tsr_pkg::DefNumActions,
  parameter int COUNT_BITS  = tsr_pkg::DefCountBits
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // state_index, action_index, next_state_index, reward_value, zero pad
  input  logic [47:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // transition_count, pair_count, mean_reward, sum_sq_diff, step_count, pad
  output logic [207:0] out_tdata
);
  localparam int PDepth = NUM_STATES * NUM_ACTIONS;
  localparam int TDepth = PDepth * NUM_STATES;
  localparam int PBits  = $clog2(PDepth);
  localparam int TBits  = $clog2(TDepth);
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  tsr_pkg::state_t state_r, state_nxt;

  logic [5:0]  st_in, nx_in;
  logic [2:0]  ac_in;
  logic signed [31:0] rew_in;
  logic        in_range;

  assign st_in  = in_tdata[5:0];
  assign ac_in  = in_tdata[8:6];
  assign nx_in  = in_tdata[14:9];
  assign rew_in = in_tdata[46:15];
  assign in_range = (32'(st_in) < NUM_STATES) && (32'(nx_in) < NUM_STATES)
                  && (32'(ac_in) < NUM_ACTIONS);

  logic [PBits-1:0] pidx_r;
  logic [TBits-1:0] tidx_r, clr_r, clr_nxt;
  logic signed [31:0] rew_r;
  logic [47:0] steps_r;

  // Memory ports
  logic                  mem_we;
  logic [PBits-1:0]      p_waddr;
  logic [TBits-1:0]      t_waddr;
  logic [COUNT_BITS-1:0] tc_rd, pc_rd, tc_wd, pc_wd;
  logic [31:0]           mn_rd, mn_wd;
  logic [62:0]           sq_rd, sq_wd;

  // Working registers
  logic [COUNT_BITS-1:0] tcnt_r, n_r;
  logic signed [31:0]    mean_old_r, mean_new_r;
  logic [62:0]           sum_old_r, sum_new_r;
  logic signed [32:0]    delta_r;
  logic [63:0]           prod_r;
  logic [207:0]          odata_r;
  logic                  ovalid_r;

  // Divider operands, taken straight from the memory read data in the load cycle.
  logic signed [32:0]    div_num;
  logic [COUNT_BITS-1:0] div_den;
  // Write-back goes ahead once the output register is free or being emptied.
  logic                  wr_go;

  tsr_pkg::div_ctrl_t dctl;
  logic               ddone;
  logic signed [33:0] dquo;

  assign div_num = 33'(rew_r) - 33'($signed(mn_rd));
  assign div_den = (pc_rd == CountMax) ? pc_rd : pc_rd + 1'b1;
  assign wr_go   = (state_r == tsr_pkg::ST_WRITE) && (!ovalid_r || out_tready);

  tsr_ram #(.Width(COUNT_BITS), .Depth(TDepth)) u_tc (
    .clk, .we(mem_we), .waddr(t_waddr), .wdata(tc_wd), .raddr(tidx_r), .rdata(tc_rd));
  tsr_ram #(.Width(COUNT_BITS), .Depth(PDepth)) u_pc (
    .clk, .we(mem_we), .waddr(p_waddr), .wdata(pc_wd), .raddr(pidx_r), .rdata(pc_rd));
  tsr_ram #(.Width(32), .Depth(PDepth)) u_mn (
    .clk, .we(mem_we), .waddr(p_waddr), .wdata(mn_wd), .raddr(pidx_r), .rdata(mn_rd));
  tsr_ram #(.Width(63), .Depth(PDepth)) u_sq (
    .clk, .we(mem_we), .waddr(p_waddr), .wdata(sq_wd), .raddr(pidx_r), .rdata(sq_rd));

  tsr_div #(.CountBits(COUNT_BITS)) u_div (
    .clk, .rst_n, .ctrl(dctl), .dividend(div_num), .divisor(div_den),
    .done(ddone), .quotient(dquo));

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    case (state_r)
      tsr_pkg::ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == TBits'(TDepth - 1)) state_nxt = tsr_pkg::ST_IDLE;
      end
      tsr_pkg::ST_IDLE:
        if (in_tvalid && in_tready && in_range) state_nxt = tsr_pkg::ST_READ;
      tsr_pkg::ST_READ:  state_nxt = tsr_pkg::ST_LOAD;
      tsr_pkg::ST_LOAD:  state_nxt = tsr_pkg::ST_DIV;
      tsr_pkg::ST_DIV:   if (ddone) state_nxt = tsr_pkg::ST_MUL;
      tsr_pkg::ST_MUL:   state_nxt = tsr_pkg::ST_ACC;
      tsr_pkg::ST_ACC:   state_nxt = tsr_pkg::ST_WRITE;
      tsr_pkg::ST_WRITE: if (!ovalid_r || out_tready) state_nxt = tsr_pkg::ST_IDLE;
      default:           state_nxt = tsr_pkg::ST_IDLE;
    endcase
  end

  // Output and control decode.
  always_comb begin
    in_tready  = (state_r == tsr_pkg::ST_IDLE);
    dctl.start = (state_r == tsr_pkg::ST_LOAD);
    dctl.busy  = (state_r == tsr_pkg::ST_DIV);
    mem_we     = (state_r == tsr_pkg::ST_CLEAR) || wr_go;
    if (state_r == tsr_pkg::ST_CLEAR) begin
      t_waddr = clr_r;
      p_waddr = clr_r[PBits-1:0];
      tc_wd = '0; pc_wd = '0; mn_wd = '0; sq_wd = '0;
    end else begin
      t_waddr = tidx_r;
      p_waddr = pidx_r;
      tc_wd = tcnt_r; pc_wd = n_r; mn_wd = mean_new_r; sq_wd = sum_new_r;
    end
  end

  logic signed [33:0] mean_sum;
  logic signed [32:0] resid;
  logic [32:0]        mag_d, mag_r;
  logic [63:0]        room;
  logic [63:0]        inc;

  always_comb begin
    mean_sum = 34'(mean_old_r) + dquo;
    resid    = 33'(rew_r) - 33'(mean_new_r);
    mag_d    = delta_r[32] ? 33'(-delta_r) : 33'(delta_r);
    mag_r    = resid[32] ? 33'(-resid) : 33'(resid);
    inc      = {16'd0, prod_r[63:16]};
    room     = 64'(63'h7FFF_FFFF_FFFF_FFFF - sum_old_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tsr_pkg::ST_CLEAR;
      clr_r    <= '0;
      steps_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (wr_go) begin
        ovalid_r <= 1'b1;
        if (steps_r != '1) steps_r <= steps_r + 48'd1;
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
    if (in_tvalid && in_tready) begin
      pidx_r <= PBits'(32'(st_in) * NUM_ACTIONS + 32'(ac_in));
      tidx_r <= TBits'((32'(st_in) * NUM_ACTIONS + 32'(ac_in)) * NUM_STATES
                        + 32'(nx_in));
      rew_r  <= rew_in;
    end
    if (state_r == tsr_pkg::ST_LOAD) begin
      tcnt_r     <= (tc_rd == CountMax) ? tc_rd : tc_rd + 1'b1;
      n_r        <= div_den;
      mean_old_r <= mn_rd;
      sum_old_r  <= sq_rd;
      delta_r    <= div_num;
    end
    if (state_r == tsr_pkg::ST_DIV && ddone) begin
      mean_new_r <= mean_sum[31:0];
    end
    if (state_r == tsr_pkg::ST_MUL) begin
      prod_r <= 64'(mag_d) * 64'(mag_r);
    end
    if (state_r == tsr_pkg::ST_ACC) begin
      sum_new_r <= (inc > room) ? 63'h7FFF_FFFF_FFFF_FFFF : sum_old_r + inc[62:0];
    end
    if (wr_go) begin
      odata_r <= {1'b0, ((steps_r != '1) ? steps_r + 48'd1 : steps_r), sum_new_r,
                  mean_new_r, 32'(n_r), 32'(tcnt_r)};
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
endmodule

// ===== rtl/core/tsr_checker.sv =====
`include "transition_stats_recorder_macros.svh"
module tsr_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [207:0] out_tdata
);
  // A pending result stays offered until it is taken.
  `TSR_ASSERT_NXT(a_keep, out_tvalid && !out_tready, out_tvalid)
  // A pending result holds its data.
  `TSR_ASSERT_NXT(a_hold, out_tvalid && !out_tready, $stable(out_tdata))
  // Pair count is never zero in a delivered result.
  `TSR_ASSERT_IMP(a_pair_nz, out_tvalid, out_tdata[63:32] != 32'd0)
  // Step count is never zero in a delivered result.
  `TSR_ASSERT_IMP(a_step_nz, out_tvalid, out_tdata[206:159] != 48'd0)
endmodule

bind transition_stats_recorder tsr_checker u_tsr_checker (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata);

// ===== bench/transition_stats_recorder_tb.sv =====
module transition_stats_recorder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumStates   = tsr_pkg::DefNumStates;
  localparam int NumActions  = tsr_pkg::DefNumActions;
  localparam int PairDepth   = NumStates * NumActions;
  localparam int TransDepth  = PairDepth * NumStates;
  localparam int WatchLimit  = 200000;
  localparam longint unsigned CountMax = 64'hFFFF_FFFF;
  localparam longint unsigned StepMax  = 64'hFFFF_FFFF_FFFF;
  localparam longint unsigned SumMax   = 64'h7FFF_FFFF_FFFF_FFFF;

  // One observed transition as it travels on in_tdata.
  typedef struct packed {
    logic [31:0] reward;
    logic [5:0]  next_state;
    logic [2:0]  action;
    logic [5:0]  state;
  } transition_t;

  // One statistics record as it travels on out_tdata.
  typedef struct packed {
    logic [47:0] steps;
    logic [62:0] sq_sum;
    logic [31:0] mean;
    logic [31:0] pair_cnt;
    logic [31:0] trans_cnt;
  } stats_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [47:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [207:0] out_tdata;

  transition_stats_recorder u_top (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata
  );

  always #1 clk = ~clk;

  // Shadow copy of the block's statistics memories.
  logic [31:0]         shadow_trans [TransDepth];
  logic [31:0]         shadow_pairs [PairDepth];
  logic signed [31:0]  shadow_means [PairDepth];
  longint unsigned     shadow_sums  [PairDepth];
  longint unsigned     shadow_steps;

  transition_t pending_transitions[$];
  stats_t      expected_stats[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off      = 1'b0;
  bit in_taken      = 1'b0;
  int mismatches    = 0;
  int quiet_cycles  = 0;
  bit failed        = 1'b0;

  // Applies one transition to the shadow state and queues the record that it
  // should produce. A transition with an index out of range changes nothing.
  function automatic void record_transition(transition_t t);
    int unsigned pidx, tidx;
    longint n, rew, mean, delta, resid;
    longint unsigned prod, term, sum;
    stats_t s;
    if (t.state >= NumStates || t.next_state >= NumStates || t.action >= NumActions)
      return;
    pidx = t.state * NumActions + t.action;
    tidx = pidx * NumStates + t.next_state;
    if (shadow_steps < StepMax) shadow_steps++;
    if (shadow_trans[tidx] != CountMax[31:0]) shadow_trans[tidx]++;
    if (shadow_pairs[pidx] != CountMax[31:0]) shadow_pairs[pidx]++;
    n     = longint'(shadow_pairs[pidx]);
    rew   = longint'(signed'(t.reward));
    mean  = longint'(shadow_means[pidx]);
    delta = rew - mean;
    // SystemVerilog division truncates toward zero, as the block does.
    mean  = mean + delta / n;
    shadow_means[pidx] = mean[31:0];
    resid = rew - mean;
    prod  = longint'(delta < 0 ? -delta : delta) * longint'(resid < 0 ? -resid : resid);
    term  = prod >> 16;
    sum   = shadow_sums[pidx];
    sum   = (term > SumMax - sum) ? SumMax : sum + term;
    shadow_sums[pidx] = sum;
    s.trans_cnt = shadow_trans[tidx];
    s.pair_cnt  = shadow_pairs[pidx];
    s.mean      = shadow_means[pidx];
    s.sq_sum    = sum[62:0];
    s.steps     = shadow_steps[47:0];
    expected_stats.push_back(s);
  endfunction

  // The driver presents a transfer at each falling edge and keeps it steady
  // until the rising edge has seen the handshake.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        if (pending_transitions.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_transitions[0];
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // The receiver, idling at random or held off entirely.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_off) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Prediction is made at acceptance so the expectation is always queued
  // before its record can come back.
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      record_transition(transition_t'(in_tdata));
      void'(pending_transitions.pop_front());
    end
  end

  // The monitor compares each accepted record with the oldest expectation.
  always @(posedge clk) begin
    stats_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = stats_t'(out_tdata[206:0]);
      if (expected_stats.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("Unexpected record %h", got);
      end else begin
        want = expected_stats.pop_front();
        if (got !== want || out_tdata[207] !== 1'b0) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: trans %0d/%0d pair %0d/%0d mean %h/%h",
                     got.trans_cnt, want.trans_cnt, got.pair_cnt, want.pair_cnt,
                     got.mean, want.mean);
            $display("          sum %0d/%0d steps %0d/%0d",
                     got.sq_sum, want.sq_sum, got.steps, want.steps);
          end
        end
      end
    end
  end

  // Watchdog: counts cycles in which no transfer happens on either side. The
  // clearing pass after reset is covered by the generous limit.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic transition_t random_transition(int hot);
    transition_t t;
    t.reward = $urandom();
    case ($urandom_range(3))
      0: t.reward = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: t.reward = {{16{t.reward[31]}}, t.reward[15:0]};
      default: ;
    endcase
    // Most transitions fall on a few busy pairs so means and sums grow deep.
    if (hot != 0) begin
      t.state  = $urandom_range(3);
      t.action = $urandom_range(1);
    end else begin
      t.state  = $urandom_range(NumStates - 1);
      t.action = $urandom_range(NumActions - 1);
    end
    t.next_state = $urandom_range(NumStates - 1);
    return t;
  endfunction

  task automatic run_phase(int count, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      pending_transitions.push_back(random_transition($urandom_range(99) < 70));
    end
    wait (pending_transitions.size() == 0);
  endtask

  initial begin
    transition_t t;
    foreach (shadow_trans[i]) shadow_trans[i] = '0;
    foreach (shadow_pairs[i]) begin
      shadow_pairs[i] = '0;
      shadow_means[i] = '0;
      shadow_sums[i]  = '0;
    end
    shadow_steps = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: index extremes, reward extremes and a swing that drives the
    // squared-difference sum hard on one pair.
    t = '{reward: 32'h0000_0000, next_state: 6'd0,  action: 3'd0, state: 6'd0};
    pending_transitions.push_back(t);
    t = '{reward: 32'h7FFF_FFFF, next_state: 6'd63, action: 3'd7, state: 6'd63};
    pending_transitions.push_back(t);
    t = '{reward: 32'h8000_0000, next_state: 6'd63, action: 3'd7, state: 6'd63};
    pending_transitions.push_back(t);
    for (int i = 0; i < 16; i++) begin
      t = '{reward: (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF,
            next_state: 6'd42, action: 3'd5, state: 6'd21};
      pending_transitions.push_back(t);
    end
    t = '{reward: 32'hFFFF_FFFF, next_state: 6'd0, action: 3'd0, state: 6'd0};
    pending_transitions.push_back(t);
    t = '{reward: 32'h0001_0000, next_state: 6'd1, action: 3'd0, state: 6'd0};
    pending_transitions.push_back(t);
    wait (pending_transitions.size() == 0);

    // Long receiver hold-off, timed in its own process, while the sender keeps
    // offering transfers.
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
    join_none
    run_phase(20, 0, 0);

    run_phase(700, 33, 53);
    run_phase(700, 53, 33);
    run_phase(600, 0, 0);

    wait (expected_stats.size() == 0);
    repeat (100) @(posedge clk);
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/tsr_pkg.sv
rtl/core/tsr_ram.sv
rtl/core/tsr_div.sv
rtl/core/transition_stats_recorder.sv
rtl/core/tsr_checker.sv
bench/transition_stats_recorder_tb.sv
